FILE: design/arc_pkg.sv
// shared types, constants and codes for the arp resolve cache
package arc_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int PENDING_SLOTS = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int NREL_W = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic CMD_ARP  = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] REG_ROUTER_IP   = 2'd2;
  localparam logic [1:0] REG_LOCAL_MAC   = 2'd3;

  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_REQUEST = 3'd1;
  localparam logic [2:0] ACT_REPLY   = 3'd2;
  localparam logic [2:0] ACT_BAD_OP  = 3'd3;
  localparam logic [2:0] ACT_DROP    = 3'd4;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] subnet_mask;
    logic [31:0] router_ip;
    logic [47:0] local_mac;
  } arc_cfg_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] ip;
  } arc_pend_t;

endpackage

FILE: design/arc_ram.sv
// generic single-port-write ram with registered read
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: design/arc_cfg.sv
// configuration registers and write port
module arc_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [47:0]           cfg_data,
  output arc_pkg::arc_cfg_t     cfg
);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arc_pkg::REG_LOCAL_IP:    cfg.local_ip    <= cfg_data[31:0];
        arc_pkg::REG_SUBNET_MASK: cfg.subnet_mask <= cfg_data[31:0];
        arc_pkg::REG_ROUTER_IP:   cfg.router_ip   <= cfg_data[31:0];
        arc_pkg::REG_LOCAL_MAC:   cfg.local_mac   <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

FILE: design/arp_resolve_cache.sv
// top level: arp cache sequencer over cache and pending-list memories
// a bad opcode item goes from S_IDLE straight to S_EMIT with no cache walk; other items
//   walk the cache one read a cycle on the cache ram, stopping at the first hit or after
//   the last entry, then pass S_DECIDE before the result is loaded
// a reply then walks the pending list (S_PREAD, S_PCMP per slot), held by any output stalls
// throughput: one item at a time, next item taken once the last result is loaded or a list walk ends
// reset: valid bits, replace pointer, config and control clear at once; no sweep
module arp_resolve_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] arp_operation,
  input  logic [31:0] peer_ip,
  input  logic [47:0] peer_mac,
  input  logic [7:0]  packet_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [7:0]  out_tag,
  output logic [47:0] frame_mac,
  output logic [31:0] target_ip,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int CW = arc_pkg::CIDX_W;
  localparam int PW = arc_pkg::PIDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CSCAN, S_DECIDE, S_EMIT, S_PREAD, S_PCMP, S_FLUSH
  } state_t;

  arc_pkg::arc_cfg_t cfg;

  arc_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  state_t state;

  // latched item
  logic        cmd;
  logic [15:0] op;
  logic [31:0] key;        // next hop or sender ip
  logic [47:0] mac;
  logic [7:0]  tag;

  // cache valid bits and replacement
  logic [arc_pkg::CACHE_ENTRIES-1:0] entry_valid;
  logic [CW-1:0] replace_pointer;

  // cache walk
  logic [CW-1:0] cnt;
  logic          issue_done;
  logic          cmp_valid;
  logic [CW-1:0] cmp_idx;
  logic          hit;
  logic [CW-1:0] hit_idx;
  logic [47:0]   hit_mac;
  logic          free_found;
  logic [CW-1:0] free_idx;

  // pending list
  logic [arc_pkg::PENDING_SLOTS-1:0] pending_valid;
  logic [PW-1:0]                   p;
  logic [arc_pkg::NREL_W-1:0]      nrel;
  logic                            held;
  logic [7:0]                      held_tag;

  // result waiting for the output register
  logic [2:0]  res_action;
  logic [7:0]  res_tag;
  logic [47:0] res_mac;
  logic [31:0] res_ip;

  // memory ports
  logic          c_we, c_re;
  logic [CW-1:0] c_waddr, c_raddr;
  logic [31:0]   ip_rd;
  logic [47:0]   mac_rd;
  logic          p_we, p_re;
  logic [PW-1:0] p_waddr;
  arc_pkg::arc_pend_t p_wdata, p_rd;

  logic [31:0] hop;
  logic        out_free;
  logic        out_load;
  logic        pfree_found;
  logic [PW-1:0] pfree_idx;
  logic [CW-1:0] learn_idx;
  logic        pmatch;

  arc_ram #(.WIDTH(32), .DEPTH(arc_pkg::CACHE_ENTRIES)) u_ip_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(key),
    .re(c_re), .raddr(c_raddr), .rdata(ip_rd)
  );

  arc_ram #(.WIDTH(48), .DEPTH(arc_pkg::CACHE_ENTRIES)) u_mac_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(mac),
    .re(c_re), .raddr(c_raddr), .rdata(mac_rd)
  );

  arc_ram #(.WIDTH($bits(arc_pkg::arc_pend_t)), .DEPTH(arc_pkg::PENDING_SLOTS)) u_pend_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p), .rdata(p_rd)
  );

  // on-subnet test picks the next hop
  assign hop = ((peer_ip & cfg.subnet_mask) == (cfg.local_ip & cfg.subnet_mask)) ?
               peer_ip : cfg.router_ip;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // output register takes a new item in these cases
  assign out_load = out_free && ((state == S_EMIT) ||
                                 (state == S_PCMP && pmatch && held) ||
                                 (state == S_FLUSH && held));

  // lowest free pending slot
  always_comb begin
    pfree_found = 1'b0;
    pfree_idx   = '0;
    for (int i = arc_pkg::PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!pending_valid[i]) begin
        pfree_found = 1'b1;
        pfree_idx   = PW'(i);
      end
    end
  end

  // cache entry that learning overwrites: known ip, else lowest free, else round-robin
  assign learn_idx = hit ? hit_idx : (free_found ? free_idx : replace_pointer);

  assign pmatch = pending_valid[p] && (p_rd.ip == key);

  always_comb begin
    c_re    = (state == S_CSCAN) && !issue_done;
    c_raddr = cnt;
    c_we    = (state == S_DECIDE) && (cmd == arc_pkg::CMD_ARP);
    c_waddr = learn_idx;
    p_re    = (state == S_PREAD);
    p_we    = (state == S_DECIDE) && (cmd == arc_pkg::CMD_SEND) && !hit && pfree_found;
    p_waddr = pfree_idx;
    p_wdata = '{tag: tag, ip: key};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_valid     <= '0;
      replace_pointer <= '0;
      pending_valid   <= '0;
      out_valid       <= 1'b0;
      held            <= 1'b0;
      nrel            <= '0;
      cmp_valid       <= 1'b0;
      issue_done      <= 1'b0;
      hit             <= 1'b0;
      free_found      <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            op         <= arp_operation;
            mac        <= peer_mac;
            tag        <= packet_tag;
            key        <= (command == arc_pkg::CMD_SEND) ? hop : peer_ip;
            cnt        <= '0;
            issue_done <= 1'b0;
            cmp_valid  <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            if (command == arc_pkg::CMD_ARP && arp_operation != arc_pkg::OP_REQUEST &&
                arp_operation != arc_pkg::OP_REPLY) begin
              res_action <= arc_pkg::ACT_BAD_OP;
              res_tag    <= '0;
              res_mac    <= '0;
              res_ip     <= '0;
              state      <= S_EMIT;
            end else begin
              state <= S_CSCAN;
            end
          end
        end
        S_CSCAN: begin
          // issue one read a cycle, compare the previous read
          if (!issue_done) begin
            cnt <= cnt + 1'b1;
            if (cnt == CW'(arc_pkg::CACHE_ENTRIES - 1)) begin
              issue_done <= 1'b1;
            end
          end
          cmp_valid <= !issue_done;
          cmp_idx   <= cnt;
          if (cmp_valid) begin
            if (entry_valid[cmp_idx] && ip_rd == key) begin
              hit     <= 1'b1;
              hit_idx <= cmp_idx;
              hit_mac <= mac_rd;
              state   <= S_DECIDE;
            end else begin
              if (!entry_valid[cmp_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= cmp_idx;
              end
              if (cmp_idx == CW'(arc_pkg::CACHE_ENTRIES - 1)) begin
                state <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          if (cmd == arc_pkg::CMD_SEND) begin
            res_ip <= '0;
            if (hit) begin
              res_action <= arc_pkg::ACT_SEND;
              res_tag    <= tag;
              res_mac    <= hit_mac;
            end else if (pfree_found) begin
              pending_valid[pfree_idx] <= 1'b1;
              res_action <= arc_pkg::ACT_REQUEST;
              res_tag    <= '0;
              res_mac    <= arc_pkg::BCAST_MAC;
              res_ip     <= key;
            end else begin
              res_action <= arc_pkg::ACT_DROP;
              res_tag    <= tag;
              res_mac    <= '0;
            end
            state <= S_EMIT;
          end else begin
            entry_valid[learn_idx] <= 1'b1;
            if (!hit && !free_found) begin
              replace_pointer <= (replace_pointer == CW'(arc_pkg::CACHE_ENTRIES - 1)) ?
                                 '0 : replace_pointer + 1'b1;
            end
            if (op == arc_pkg::OP_REQUEST) begin
              res_action <= arc_pkg::ACT_REPLY;
              res_tag    <= '0;
              res_mac    <= mac;
              res_ip     <= key;
              state      <= S_EMIT;
            end else begin
              p     <= '0;
              nrel  <= '0;
              held  <= 1'b0;
              state <= S_PREAD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            action    <= res_action;
            out_tag   <= res_tag;
            frame_mac <= res_mac;
            target_ip <= res_ip;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_PREAD: begin
          state <= (nrel == arc_pkg::NREL_W'(arc_pkg::MAX_RESULTS)) ? S_FLUSH : S_PCMP;
        end
        S_PCMP: begin
          // one release is held back so the final one can carry last
          if (!(pmatch && held && !out_free)) begin
            if (pmatch) begin
              if (held) begin
                action    <= arc_pkg::ACT_SEND;
                out_tag   <= held_tag;
                frame_mac <= mac;
                target_ip <= '0;
                last      <= 1'b0;
              end
              held             <= 1'b1;
              held_tag         <= p_rd.tag;
              pending_valid[p] <= 1'b0;
              nrel             <= nrel + 1'b1;
            end
            if (p == PW'(arc_pkg::PENDING_SLOTS - 1)) begin
              state <= S_FLUSH;
            end else begin
              p     <= p + 1'b1;
              state <= S_PREAD;
            end
          end
        end
        S_FLUSH: begin
          if (!held) begin
            state <= S_IDLE;
          end else if (out_free) begin
            action    <= arc_pkg::ACT_SEND;
            out_tag   <= held_tag;
            frame_mac <= mac;
            target_ip <= '0;
            last      <= 1'b1;
            held      <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // release count never passes the per-item limit
  a_nrel_limit: assert property (@(posedge clk) disable iff (rst)
    nrel <= arc_pkg::NREL_W'(arc_pkg::MAX_RESULTS))
    else $error("release count over limit");

  // a datagram is parked only in a free slot
  a_park_free: assert property (@(posedge clk) disable iff (rst)
    p_we |-> !pending_valid[p_waddr])
    else $error("parking over a used slot");

  // an accepted item stalls the input in the cycle after it is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken back to back");

  // a cache hit always comes from a valid entry
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && hit) |-> entry_valid[hit_idx])
    else $error("hit on an invalid entry");
endmodule

FILE: verif/arc_checker.sv
// checker for the arp resolve cache: predicts and compares every result item
`timescale 1ns / 1ps
module arc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [15:0] arp_operation,
  input  logic [31:0] peer_ip,
  input  logic [47:0] peer_mac,
  input  logic [7:0]  packet_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  out_tag,
  input  logic [47:0] frame_mac,
  input  logic [31:0] target_ip,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned results_due
);

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  tag;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        fin;
  } resolve_t;

  resolve_t          due_q[$];
  arc_pkg::arc_cfg_t regs;
  logic        known_ok  [arc_pkg::CACHE_ENTRIES];
  logic [31:0] known_ip  [arc_pkg::CACHE_ENTRIES];
  logic [47:0] known_mac [arc_pkg::CACHE_ENTRIES];
  logic [arc_pkg::CIDX_W-1:0] victim;
  logic        parked_ok [arc_pkg::PENDING_SLOTS];
  logic [7:0]  parked_tag[arc_pkg::PENDING_SLOTS];
  logic [31:0] parked_hop[arc_pkg::PENDING_SLOTS];

  function automatic int lookup(logic [31:0] ip);
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++)
      if (known_ok[i] && known_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void push_due(logic [2:0] a, logic [7:0] t, logic [47:0] m,
                                   logic [31:0] ip, logic f);
    resolve_t r;
    r.act = a; r.tag = t; r.mac = m; r.ip = ip; r.fin = f;
    due_q.push_back(r);
  endfunction

  function automatic void learn_pair(logic [31:0] ip, logic [47:0] mac);
    int e;
    e = lookup(ip);
    if (e < 0) begin
      for (int i = 0; i < arc_pkg::CACHE_ENTRIES && e < 0; i++)
        if (!known_ok[i]) e = i;
      if (e < 0) begin
        e = victim;
        victim = victim + 1'b1;
      end
      known_ok[e] = 1'b1;
      known_ip[e] = ip;
    end
    known_mac[e] = mac;
  endfunction

  function automatic void predict_item();
    int n, e, slot;
    logic [31:0] hop;
    n = 0;
    if (command == arc_pkg::CMD_ARP) begin
      if (arp_operation == arc_pkg::OP_REQUEST) begin
        learn_pair(peer_ip, peer_mac);
        push_due(arc_pkg::ACT_REPLY, 8'd0, peer_mac, peer_ip, 1'b1);
      end else if (arp_operation == arc_pkg::OP_REPLY) begin
        learn_pair(peer_ip, peer_mac);
        for (int i = 0; i < arc_pkg::PENDING_SLOTS && n < arc_pkg::MAX_RESULTS; i++)
          if (parked_ok[i] && parked_hop[i] == peer_ip) begin
            parked_ok[i] = 1'b0;
            push_due(arc_pkg::ACT_SEND, parked_tag[i], peer_mac, 32'd0, 1'b0);
            n++;
          end
        // mark the final release
        if (n > 0) due_q[$].fin = 1'b1;
      end else begin
        push_due(arc_pkg::ACT_BAD_OP, 8'd0, 48'd0, 32'd0, 1'b1);
      end
    end else begin
      if ((peer_ip & regs.subnet_mask) == (regs.local_ip & regs.subnet_mask)) hop = peer_ip;
      else hop = regs.router_ip;
      e = lookup(hop);
      if (e >= 0) begin
        push_due(arc_pkg::ACT_SEND, packet_tag, known_mac[e], 32'd0, 1'b1);
      end else begin
        slot = -1;
        for (int i = 0; i < arc_pkg::PENDING_SLOTS && slot < 0; i++)
          if (!parked_ok[i]) slot = i;
        if (slot < 0) begin
          push_due(arc_pkg::ACT_DROP, packet_tag, 48'd0, 32'd0, 1'b1);
        end else begin
          parked_ok[slot]  = 1'b1;
          parked_tag[slot] = packet_tag;
          parked_hop[slot] = hop;
          push_due(arc_pkg::ACT_REQUEST, 8'd0, arc_pkg::BCAST_MAC, hop, 1'b1);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    resolve_t want;
    if (rst) begin
      regs = '0;
      victim = '0;
      due_q.delete();
      fail_count = 0;
      for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++) known_ok[i] = 1'b0;
      for (int i = 0; i < arc_pkg::PENDING_SLOTS; i++) parked_ok[i] = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          arc_pkg::REG_LOCAL_IP:    regs.local_ip    = cfg_data[31:0];
          arc_pkg::REG_SUBNET_MASK: regs.subnet_mask = cfg_data[31:0];
          arc_pkg::REG_ROUTER_IP:   regs.router_ip   = cfg_data[31:0];
          arc_pkg::REG_LOCAL_MAC:   regs.local_mac   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected result item: action %0d tag %0h", action, out_tag);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          if (action !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, action); fail_count++;
          end
          if (out_tag !== want.tag) begin
            $error("out_tag: expected %0h, got %0h", want.tag, out_tag); fail_count++;
          end
          if (frame_mac !== want.mac) begin
            $error("frame_mac: expected %0h, got %0h", want.mac, frame_mac); fail_count++;
          end
          if (target_ip !== want.ip) begin
            $error("target_ip: expected %0h, got %0h", want.ip, target_ip); fail_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, last); fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_item();
    end
    results_due = due_q.size();
  end

endmodule

FILE: verif/tb_arp_resolve_cache.sv
// testbench top for the arp resolve cache: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_arp_resolve_cache;

  localparam int DRAIN_CYCLES = 200;     // covers a full cache walk plus a list walk
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [15:0] arp_operation = '0;
  logic [31:0] peer_ip = '0;
  logic [47:0] peer_mac = '0;
  logic [7:0]  packet_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [7:0]  out_tag;
  logic [47:0] frame_mac;
  logic [31:0] target_ip;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned cycles = 0;
  logic        steady = 1'b0;   // no idling on either side while set

  // current network setup, used to aim datagrams and replies
  logic [31:0] net_base;
  logic [31:0] net_gateway;

  always #1 clk = ~clk;

  arp_resolve_cache dut (.*);

  arc_checker u_checker (.*);

  // receiver side stalls at random, except in the steady stretch
  always @(negedge clk) out_stall <= !steady && ($urandom_range(0, 99) < 31);

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_arp_resolve_cache: done, errors");
      $finish;
    end
  end

  function automatic logic [47:0] any_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_net(logic [31:0] ip, logic [31:0] mask, logic [31:0] gw,
                           logic [47:0] mac);
    write_reg(arc_pkg::REG_LOCAL_IP, {16'd0, ip});
    write_reg(arc_pkg::REG_SUBNET_MASK, {16'd0, mask});
    write_reg(arc_pkg::REG_ROUTER_IP, {16'd0, gw});
    write_reg(arc_pkg::REG_LOCAL_MAC, mac);
    net_base    = ip & mask;
    net_gateway = gw;
  endtask

  // one item on the input channel, sometimes with a random idle gap in front of it
  task automatic send_item(logic cmd, logic [15:0] op, logic [31:0] ip,
                           logic [47:0] mac, logic [7:0] tag);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 31) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    arp_operation <= op;
    peer_ip       <= ip;
    peer_mac      <= mac;
    packet_tag    <= tag;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly well-formed traffic around a small set of hosts, some noise
  task automatic random_traffic(int count);
    int pick;
    logic [31:0] host;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      host = ($urandom_range(0, 9) == 0) ? net_gateway : (net_base | $urandom_range(0, 15));
      if (pick < 30)
        send_item(arc_pkg::CMD_SEND, 16'($urandom),
                  ($urandom_range(0, 99) < 70) ? host : $urandom,
                  any_mac(), 8'($urandom));
      else if (pick < 50)
        send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REPLY, host, any_mac(), 8'($urandom));
      else if (pick < 65)
        send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REQUEST, host, any_mac(), 8'($urandom));
      else if (pick < 72)
        send_item(arc_pkg::CMD_ARP, 16'($urandom_range(0, 65535)), $urandom, any_mac(),
                  8'($urandom));
      else
        // fresh addresses push the cache into round-robin replacement
        send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REQUEST, $urandom, any_mac(), 8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    setup_net(32'h0A00_0001, 32'hFFFF_FF00, 32'h0A00_00FE, 48'h02AA_BBCC_DDEE);

    // miss parks the datagram and asks for the host
    send_item(arc_pkg::CMD_SEND, 16'hFFFF, 32'h0A00_0005, 48'd0, 8'h00);
    // unknown opcodes at both ends of the range
    send_item(arc_pkg::CMD_ARP, 16'h0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_item(arc_pkg::CMD_ARP, 16'hFFFF, 32'h0000_0000, 48'h0, 8'h00);
    // reply releases the parked datagram, then a hit goes out at once
    send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REPLY, 32'h0A00_0005, 48'h1234_5678_9ABC, 8'h00);
    send_item(arc_pkg::CMD_SEND, 16'h0000, 32'h0A00_0005, 48'h0, 8'hFF);
    // request answered; same address learned again overwrites the mac
    send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REQUEST, 32'h0A00_0009, 48'hFFFF_FFFF_FFFF, 8'h00);
    send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REQUEST, 32'h0A00_0009, 48'h0, 8'h00);
    send_item(arc_pkg::CMD_SEND, 16'h0000, 32'h0A00_0009, 48'h0, 8'h5A);
    // reply with nothing parked: learned quietly
    send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REPLY, 32'h0A00_0077, 48'hA5A5_A5A5_A5A5, 8'h00);
    // off-subnet traffic parks under the gateway until the list is full, then drops
    for (int k = 0; k < arc_pkg::PENDING_SLOTS + 1; k++)
      send_item(arc_pkg::CMD_SEND, 16'h0000, 32'h0808_0808 + k, 48'h0, 8'($urandom));
    // gateway answers and every parked datagram leaves in one burst
    send_item(arc_pkg::CMD_ARP, arc_pkg::OP_REPLY, 32'h0A00_00FE, 48'h0000_0000_0001, 8'h00);
    settle();

    random_traffic(15);
    steady = 1'b1;
    random_traffic(15);
    steady = 1'b0;
    random_traffic(15);
    settle();

    // extreme setup: all-ones mask leaves only the local address on the subnet, gateway zero
    setup_net(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    random_traffic(25);
    settle();

    // opposite extreme: zero mask puts every destination on the subnet
    setup_net(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 48'h0);
    random_traffic(10);
    settle();

    if (fail_count == 0)
      $display("tb_arp_resolve_cache: done, clean");
    else
      $display("tb_arp_resolve_cache: done, errors");
    $finish;
  end

endmodule
